/* hw/rtl/rti_pkg.sv */
// Shared types and constants of the ray against triangle intersection block.
package rti_pkg;

    localparam int COORD_BITS    = 21;
    localparam int FRAC_BITS     = 10;
    localparam int MATERIAL_BITS = 8;
    localparam int T_FRAC        = 16;
    localparam int T_BITS        = 32;
    localparam int DOT_BITS      = 44;
    localparam int PNT_BITS      = COORD_BITS + 1;
    localparam int NUM_BITS      = 45;
    localparam int NMAG_BITS     = NUM_BITS + T_FRAC;
    localparam int Q_BITS        = 33;
    localparam int DIV_STAGES    = Q_BITS + 1;
    localparam int EDGE_STAGES   = 4;
    localparam int REG_IDX_BITS  = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } reg_idx_t;

    // Element 0 is x and sits in the low bits; take elements through $signed.
    typedef logic [2:0][COORD_BITS-1:0] vec_t;
    typedef logic [2:0][PNT_BITS-1:0]   pvec_t;

    localparam vec_t DIR_RESET = {COORD_BITS'(1 << FRAC_BITS), COORD_BITS'(0), COORD_BITS'(0)};

    typedef struct packed {
        logic [3*COORD_BITS-1:0]  vertex_a;
        logic [3*COORD_BITS-1:0]  vertex_b;
        logic [3*COORD_BITS-1:0]  vertex_c;
        logic [3*COORD_BITS-1:0]  normal_vec;
        logic [MATERIAL_BITS-1:0] material_tag;
    } in_t;

    typedef struct packed {
        logic                       hit;
        logic signed [T_BITS-1:0]   hit_distance;
        logic signed [DOT_BITS-1:0] dir_dot_normal;
        logic [MATERIAL_BITS-1:0]   hit_material;
    } out_t;

    typedef struct packed {
        logic pos;
        logic zero;
    } edge_flag_t;

endpackage

/* hw/rtl/rti_div.sv */
// Pipelined restoring divider: one quotient bit per stage, overflow flag up front.
module rti_div
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [rti_pkg::NMAG_BITS-1:0] num_mag,
    input  logic [rti_pkg::DOT_BITS-1:0]  den_mag,
    output logic [rti_pkg::Q_BITS-1:0]    quot,
    output logic                          ovf
);
    import rti_pkg::*;

    localparam int CMP_BITS = DOT_BITS + Q_BITS + 1;

    logic [NMAG_BITS-1:0] rem_reg  [DIV_STAGES];
    logic [DOT_BITS-1:0]  den_reg  [DIV_STAGES];
    logic [Q_BITS-1:0]    quot_reg [DIV_STAGES];
    logic                 ovf_reg  [DIV_STAGES];
    logic [CMP_BITS-1:0]  shd      [DIV_STAGES];
    logic                 take     [DIV_STAGES];

    // Stage 0 flags a quotient of 2^Q_BITS or more; stage i settles bit Q_BITS-i.
    always_comb
    begin
        shd[0]  = CMP_BITS'(den_mag) << Q_BITS;
        take[0] = CMP_BITS'(num_mag) >= shd[0];
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            shd[i]  = CMP_BITS'(den_reg[i-1]) << (Q_BITS - i);
            take[i] = CMP_BITS'(rem_reg[i-1]) >= shd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_mag;
            den_reg[0]  <= den_mag;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= take[0];
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                rem_reg[i]  <= take[i] ? NMAG_BITS'(CMP_BITS'(rem_reg[i-1]) - shd[i])
                                       : rem_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                quot_reg[i] <= quot_reg[i-1] | (Q_BITS'(take[i]) << (Q_BITS - i));
                ovf_reg[i]  <= ovf_reg[i-1];
            end
        end
    end

    assign quot = quot_reg[DIV_STAGES-1];
    assign ovf  = ovf_reg[DIV_STAGES-1];

endmodule

/* hw/rtl/rti_edge.sv */
// Pipelined exact edge test: sign of ((vb - va) x (p - va)) . n.
module rti_edge
(
    input  logic                clk,
    input  logic                en,
    input  rti_pkg::vec_t       va,
    input  rti_pkg::vec_t       vb,
    input  rti_pkg::pvec_t      pt,
    input  rti_pkg::vec_t       nv,
    output rti_pkg::edge_flag_t flag
);
    import rti_pkg::*;

    localparam int E_BITS  = COORD_BITS + 1;
    localparam int W_BITS  = PNT_BITS + 1;
    localparam int M_BITS  = E_BITS + W_BITS;
    localparam int C_BITS  = M_BITS + 1;
    localparam int CN_BITS = C_BITS + COORD_BITS;
    localparam int S_BITS  = CN_BITS + 2;

    logic signed [E_BITS-1:0]  e_reg  [3];
    logic signed [W_BITS-1:0]  w_reg  [3];
    logic signed [M_BITS-1:0]  m_reg  [6];
    logic signed [C_BITS-1:0]  c_reg  [3];
    logic signed [CN_BITS-1:0] cn_reg [3];
    vec_t                      n1_reg;
    vec_t                      n2_reg;
    vec_t                      n3_reg;
    logic signed [S_BITS-1:0]  sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i] <= E_BITS'($signed(vb[i])) - E_BITS'($signed(va[i]));
                w_reg[i] <= W_BITS'($signed(pt[i])) - W_BITS'($signed(va[i]));
            end
            n1_reg <= nv;

            m_reg[0] <= M_BITS'(e_reg[1]) * M_BITS'(w_reg[2]);
            m_reg[1] <= M_BITS'(e_reg[2]) * M_BITS'(w_reg[1]);
            m_reg[2] <= M_BITS'(e_reg[2]) * M_BITS'(w_reg[0]);
            m_reg[3] <= M_BITS'(e_reg[0]) * M_BITS'(w_reg[2]);
            m_reg[4] <= M_BITS'(e_reg[0]) * M_BITS'(w_reg[1]);
            m_reg[5] <= M_BITS'(e_reg[1]) * M_BITS'(w_reg[0]);
            n2_reg   <= n1_reg;

            c_reg[0] <= C_BITS'(m_reg[0]) - C_BITS'(m_reg[1]);
            c_reg[1] <= C_BITS'(m_reg[2]) - C_BITS'(m_reg[3]);
            c_reg[2] <= C_BITS'(m_reg[4]) - C_BITS'(m_reg[5]);
            n3_reg   <= n2_reg;

            for (int i = 0; i < 3; i++)
            begin
                cn_reg[i] <= CN_BITS'(c_reg[i]) * CN_BITS'($signed(n3_reg[i]));
            end
        end
    end

    assign sum       = S_BITS'(cn_reg[0]) + S_BITS'(cn_reg[1]) + S_BITS'(cn_reg[2]);
    assign flag.zero = (sum == '0);
    assign flag.pos  = !sum[S_BITS-1] && (sum != '0);

endmodule

/* hw/rtl/ray_triangle_intersection.sv */
// Top level of the ray against triangle intersection pipeline.
//
// Tests one triangle per request against a ray held in six configuration
// registers (origin and direction, signed Q10.10). Each request carries three
// vertices, a normal and a material tag; each result carries the hit flag,
// t in signed Q15.16 (truncated toward zero, saturated), normal dot direction
// in Q23.20 and the material tag. A new request is taken every clock cycle
// while the output is not stalled. The first stages form the plane numerator
// and denominator, the divider then produces t one quotient bit per stage,
// the next stages form the hit point, the edge stages test the edges a to b,
// b to c and c to a, and one final register holds the result. The whole
// pipeline advances together: while a finished result waits to be taken,
// every stage holds, and it moves again as soon as the output register is
// emptied or taken. Write configuration only while no request is in flight.
module ray_triangle_intersection
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rti_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  logic [rti_pkg::COORD_BITS-1:0]   cfg_data,
    input  logic                            tri_valid,
    output logic                            tri_ready,
    input  rti_pkg::in_t                    tri_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output rti_pkg::out_t                   res_data
);
    import rti_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PN_BITS   = COORD_BITS + DIFF_BITS;
    localparam int PD_BITS   = 2 * COORD_BITS;
    localparam int PR_BITS   = T_BITS + COORD_BITS;
    localparam int PS_BITS   = PR_BITS - T_FRAC + 1;

    localparam logic signed [T_BITS-1:0] T_MAX = {1'b0, {(T_BITS-1){1'b1}}};
    localparam logic signed [T_BITS-1:0] T_MIN = {1'b1, {(T_BITS-1){1'b0}}};

    // Request fields and partial results that ride along the pipeline.
    typedef struct packed {
        vec_t                       a;
        vec_t                       b;
        vec_t                       c;
        vec_t                       n;
        logic [MATERIAL_BITS-1:0]   material;
        logic signed [DOT_BITS-1:0] den;
        logic                       neg;
        logic                       den_zero;
        logic signed [T_BITS-1:0]   t;
        logic                       ok;
    } side_t;

    // Ray registers
    vec_t origin_reg;
    vec_t dir_reg;

    // Global advance: every stage moves when the output slot is free or taken
    logic adv;

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg, side7_reg;
    side_t side1_next, side3_next, side4_next, side5_next, side7_next;

    logic signed [DIFF_BITS-1:0] diff1_reg [3];
    logic signed [PN_BITS-1:0]   pn2_reg   [3];
    logic signed [PD_BITS-1:0]   pd2_reg   [3];
    logic signed [NUM_BITS-1:0]  num3_reg;
    logic [NMAG_BITS-1:0]        nmag4_reg;
    logic [DOT_BITS-1:0]         dmag4_reg;
    logic signed [PR_BITS-1:0]   pr6_reg   [3];
    pvec_t                       p7_reg;
    pvec_t                       p7_next;
    logic signed [PS_BITS-1:0]   ps        [3];
    logic                        in_range;

    logic [NUM_BITS-1:0] num_abs;
    logic [DOT_BITS-1:0] den_abs;

    logic [Q_BITS-1:0] quot;
    logic              ovf;
    logic              sat_pos;
    logic              sat_neg;

    logic  vd_reg    [DIV_STAGES];
    side_t sided_reg [DIV_STAGES];
    logic  ve_reg    [EDGE_STAGES];
    side_t sidee_reg [EDGE_STAGES];

    edge_flag_t flag_ab, flag_bc, flag_ca;

    logic res_valid_reg;
    out_t res_reg;

    assign adv       = !res_valid_reg || res_ready;
    assign tri_ready = adv;

    // Configuration writes; an index past the last register is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            dir_reg    <= DIR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0]    <= cfg_data;
                REG_DIR_Y:    dir_reg[1]    <= cfg_data;
                REG_DIR_Z:    dir_reg[2]    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Valid bits travel with their stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
            for (int i = 0; i < EDGE_STAGES; i++)
            begin
                ve_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= tri_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            v5_reg    <= vd_reg[DIV_STAGES-1];
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            ve_reg[0] <= v7_reg;
            for (int i = 1; i < EDGE_STAGES; i++)
            begin
                ve_reg[i] <= ve_reg[i-1];
            end
            res_valid_reg <= ve_reg[EDGE_STAGES-1];
        end
    end

    // Stage 1: unpack the request, subtract the origin from vertex a
    always_comb
    begin
        side1_next          = '0;
        side1_next.a        = vec_t'(tri_data.vertex_a);
        side1_next.b        = vec_t'(tri_data.vertex_b);
        side1_next.c        = vec_t'(tri_data.vertex_c);
        side1_next.n        = vec_t'(tri_data.normal_vec);
        side1_next.material = tri_data.material_tag;
    end

    // Stages 3 and 4: denominator sum, then quotient sign and zero check
    always_comb
    begin
        side3_next     = side2_reg;
        side3_next.den = DOT_BITS'(pd2_reg[0]) + DOT_BITS'(pd2_reg[1])
                       + DOT_BITS'(pd2_reg[2]);

        side4_next          = side3_reg;
        side4_next.neg      = num3_reg[NUM_BITS-1] ^ side3_reg.den[DOT_BITS-1];
        side4_next.den_zero = (side3_reg.den == '0);
    end

    // Stage 5: signed t with saturation; a zero denominator means no hit
    always_comb
    begin
        sat_pos = ovf || quot[Q_BITS-1] || quot[T_BITS-1];
        sat_neg = ovf || quot[Q_BITS-1] || (quot[T_BITS-1] && (quot[T_BITS-2:0] != '0));
        side5_next = sided_reg[DIV_STAGES-1];
        if (side5_next.den_zero)
        begin
            side5_next.t  = '0;
            side5_next.ok = 1'b0;
        end
        else if (side5_next.neg)
        begin
            side5_next.t  = sat_neg ? T_MIN : -$signed(quot[T_BITS-1:0]);
            side5_next.ok = !sat_neg;
        end
        else
        begin
            side5_next.t  = sat_pos ? T_MAX : $signed(quot[T_BITS-1:0]);
            side5_next.ok = !sat_pos;
        end
    end

    // Stage 7: hit point, dropped as a miss when it does not fit the widened point range
    always_comb
    begin
        in_range = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            ps[i] = PS_BITS'($signed(origin_reg[i])) + PS_BITS'(pr6_reg[i] >>> T_FRAC);
            if ((ps[i][PS_BITS-1:PNT_BITS-1] != '0) && (ps[i][PS_BITS-1:PNT_BITS-1] != '1))
            begin
                in_range = 1'b0;
            end
            p7_next[i] = ps[i][PNT_BITS-1:0];
        end
        side7_next    = side6_reg;
        side7_next.ok = side6_reg.ok && in_range;
    end

    assign num_abs = num3_reg[NUM_BITS-1] ? NUM_BITS'(-num3_reg) : NUM_BITS'(num3_reg);
    assign den_abs = side3_reg.den[DOT_BITS-1] ? DOT_BITS'(-side3_reg.den)
                                               : DOT_BITS'(side3_reg.den);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1
            side1_reg <= side1_next;
            for (int i = 0; i < 3; i++)
            begin
                diff1_reg[i] <= DIFF_BITS'($signed(side1_next.a[i]))
                              - DIFF_BITS'($signed(origin_reg[i]));
            end

            // Stage 2: products of the normal with (a - origin) and with the direction
            side2_reg <= side1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pn2_reg[i] <= PN_BITS'($signed(side1_reg.n[i])) * PN_BITS'(diff1_reg[i]);
                pd2_reg[i] <= PD_BITS'($signed(side1_reg.n[i])) * PD_BITS'($signed(dir_reg[i]));
            end

            // Stage 3: numerator and denominator sums
            side3_reg <= side3_next;
            num3_reg  <= NUM_BITS'(pn2_reg[0]) + NUM_BITS'(pn2_reg[1])
                       + NUM_BITS'(pn2_reg[2]);

            // Stage 4: sign and magnitude for the divider
            side4_reg <= side4_next;
            nmag4_reg <= {num_abs, {T_FRAC{1'b0}}};
            dmag4_reg <= den_abs;

            // Divider side line
            sided_reg[0] <= side4_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                sided_reg[i] <= sided_reg[i-1];
            end

            // Stage 5
            side5_reg <= side5_next;

            // Stage 6: t times direction
            side6_reg <= side5_reg;
            for (int i = 0; i < 3; i++)
            begin
                pr6_reg[i] <= PR_BITS'(side5_reg.t) * PR_BITS'($signed(dir_reg[i]));
            end

            // Stage 7
            side7_reg <= side7_next;
            p7_reg    <= p7_next;

            // Edge side line
            sidee_reg[0] <= side7_reg;
            for (int i = 1; i < EDGE_STAGES; i++)
            begin
                sidee_reg[i] <= sidee_reg[i-1];
            end

            // Output register: edge a to b is strict, the other two allow zero
            res_reg.hit            <= sidee_reg[EDGE_STAGES-1].ok && flag_ab.pos
                                   && (flag_bc.pos || flag_bc.zero)
                                   && (flag_ca.pos || flag_ca.zero);
            res_reg.hit_distance   <= sidee_reg[EDGE_STAGES-1].t;
            res_reg.dir_dot_normal <= sidee_reg[EDGE_STAGES-1].den;
            res_reg.hit_material   <= sidee_reg[EDGE_STAGES-1].material;
        end
    end

    rti_div u_div
    (
        .clk     (clk),
        .en      (adv),
        .num_mag (nmag4_reg),
        .den_mag (dmag4_reg),
        .quot    (quot),
        .ovf     (ovf)
    );

    rti_edge u_edge_ab
    (
        .clk  (clk),
        .en   (adv),
        .va   (side7_reg.a),
        .vb   (side7_reg.b),
        .pt   (p7_reg),
        .nv   (side7_reg.n),
        .flag (flag_ab)
    );

    rti_edge u_edge_bc
    (
        .clk  (clk),
        .en   (adv),
        .va   (side7_reg.b),
        .vb   (side7_reg.c),
        .pt   (p7_reg),
        .nv   (side7_reg.n),
        .flag (flag_bc)
    );

    rti_edge u_edge_ca
    (
        .clk  (clk),
        .en   (adv),
        .va   (side7_reg.c),
        .vb   (side7_reg.a),
        .pt   (p7_reg),
        .nv   (side7_reg.n),
        .flag (flag_ca)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // A hit needs a ray that is not parallel to the plane
    a_hit_needs_den: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.hit |-> res_reg.dir_dot_normal != '0)
        else $error("hit reported with zero normal dot direction");

    // A parallel ray yields t of zero and no hit
    a_parallel_zero_t: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && side5_reg.den_zero |-> (side5_reg.t == '0) && !side5_reg.ok)
        else $error("parallel ray produced a non-zero distance or a valid hit");

    // Hold the pipeline while the output is stalled
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(side1_reg) && $stable(v7_reg))
        else $error("pipeline moved during an output stall");

endmodule
